/* sv/leb_pkg.sv */
// Shared constants and types for the line edit buffer.
package leb_pkg;

  localparam int LINE_CAPACITY_DEF = 32;

  localparam int CHAR_W     = 8;
  localparam int KIND_W     = 2;
  localparam int LEN_W      = 6;
  localparam int MAX_COPY_W = 7;

  localparam logic [MAX_COPY_W-1:0] MAX_COPY_RESET = 7'd64;

  localparam logic [CHAR_W-1:0] KEY_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] KEY_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] PRINT_LOW     = 8'h20;
  localparam logic [CHAR_W-1:0] PRINT_HIGH    = 8'h7E;

  localparam logic [KIND_W-1:0] KIND_ECHO = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CHAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_WR   = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

endpackage

/* sv/leb_if.sv */
// Key input and result output channel interfaces.
interface leb_key_if;
  logic                       valid;
  logic                       ready;
  logic [leb_pkg::CHAR_W-1:0] char_code;

  modport source(output valid, output char_code, input ready);
  modport sink(input valid, input char_code, output ready);
endinterface

interface leb_res_if;
  logic                       valid;
  logic                       ready;
  logic [leb_pkg::KIND_W-1:0] kind;
  logic [leb_pkg::CHAR_W-1:0] data;
  logic [leb_pkg::LEN_W-1:0]  line_length;
  logic                       last;

  modport source(output valid, output kind, output data, output line_length, output last,
                 input ready);
  modport sink(input valid, input kind, input data, input line_length, input last,
               output ready);
endinterface

/* sv/leb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module leb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/line_edit_buffer.sv */
// Line edit buffer top level: key handling, line store and delivery sequencer.
//
//  channel  dir  handshake          payload
//  key      in   valid/ready        char_code[7:0]
//  res      out  valid/ready        kind[1:0] data[7:0] line_length[5:0] last
//  cfg      in   cfg_we, no ready   cfg_wdata[6:0] (max_copy)
//
// Backspace, printable and ignored keys are handled without leaving idle.
// Newline passes through S_RD and S_WR for each delivered character, then S_DONE:
// each character is one line store read followed by one output register load.
// The line store has no reset; only entries below the fill count are read.
// A stalled result holds the output register; keys are taken only in idle
// with the output register free or being drained.
module line_edit_buffer #(
  parameter int LINE_CAPACITY = leb_pkg::LINE_CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [leb_pkg::MAX_COPY_W-1:0] cfg_wdata,
  leb_key_if.sink                        key,
  leb_res_if.source                      res
);

  localparam int AW = $clog2(LINE_CAPACITY);
  localparam logic [AW-1:0] FULL_COUNT = AW'(LINE_CAPACITY - 1);

  leb_pkg::state_t state, state_next;

  logic [leb_pkg::MAX_COPY_W-1:0] max_copy;
  logic [AW-1:0] fill, fill_next;
  logic [AW-1:0] len, len_next;
  logic [AW-1:0] idx, idx_next;

  logic                         out_valid, out_valid_next;
  logic [leb_pkg::KIND_W-1:0]   out_kind, out_kind_next;
  logic [leb_pkg::CHAR_W-1:0]   out_data, out_data_next;
  logic [leb_pkg::LEN_W-1:0]    out_len, out_len_next;
  logic                         out_last, out_last_next;

  logic                         ram_we, ram_re;
  logic [leb_pkg::CHAR_W-1:0]   ram_rdata;
  logic                         slot_free;
  logic [leb_pkg::MAX_COPY_W-1:0] limit, fill_ext, len_calc;

  leb_ram #(
    .WIDTH(leb_pkg::CHAR_W),
    .DEPTH(LINE_CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(fill),
    .wdata(key.char_code),
    .re   (ram_re),
    .raddr(idx),
    .rdata(ram_rdata)
  );

  assign slot_free = !out_valid || res.ready;
  assign key.ready = (state == leb_pkg::S_IDLE) && slot_free;

  assign limit    = (max_copy == '0) ? '0 : max_copy - 1'b1;
  assign fill_ext = leb_pkg::MAX_COPY_W'(fill);
  assign len_calc = (fill_ext < limit) ? fill_ext : limit;

  always_comb begin
    state_next     = state;
    fill_next      = fill;
    len_next       = len;
    idx_next       = idx;
    out_valid_next = out_valid && !res.ready;
    out_kind_next  = out_kind;
    out_data_next  = out_data;
    out_len_next   = out_len;
    out_last_next  = out_last;
    ram_we         = 1'b0;
    ram_re         = 1'b0;

    case (state)
      leb_pkg::S_IDLE: begin
        if (key.valid && key.ready) begin
          case (key.char_code)
            leb_pkg::KEY_BACKSPACE: begin
              if (fill != '0) begin
                fill_next      = fill - 1'b1;
                out_valid_next = 1'b1;
                out_kind_next  = leb_pkg::KIND_ECHO;
                out_data_next  = leb_pkg::KEY_BACKSPACE;
                out_len_next   = '0;
                out_last_next  = 1'b1;
              end
            end
            leb_pkg::KEY_NEWLINE: begin
              out_valid_next = 1'b1;
              out_kind_next  = leb_pkg::KIND_ECHO;
              out_data_next  = leb_pkg::KEY_NEWLINE;
              out_len_next   = '0;
              out_last_next  = 1'b0;
              len_next       = AW'(len_calc);
              idx_next       = '0;
              state_next     = (len_calc == '0) ? leb_pkg::S_DONE : leb_pkg::S_RD;
            end
            default: begin
              if ((key.char_code inside {[leb_pkg::PRINT_LOW:leb_pkg::PRINT_HIGH]}) &&
                  (fill != FULL_COUNT)) begin
                ram_we         = 1'b1;
                fill_next      = fill + 1'b1;
                out_valid_next = 1'b1;
                out_kind_next  = leb_pkg::KIND_ECHO;
                out_data_next  = key.char_code;
                out_len_next   = '0;
                out_last_next  = 1'b1;
              end
            end
          endcase
        end
      end
      leb_pkg::S_RD: begin
        ram_re     = 1'b1;
        state_next = leb_pkg::S_WR;
      end
      leb_pkg::S_WR: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_kind_next  = leb_pkg::KIND_CHAR;
          out_data_next  = ram_rdata;
          out_len_next   = '0;
          out_last_next  = 1'b0;
          if (idx == len - 1'b1) begin
            state_next = leb_pkg::S_DONE;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = leb_pkg::S_RD;
          end
        end
      end
      leb_pkg::S_DONE: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_kind_next  = leb_pkg::KIND_DONE;
          out_data_next  = '0;
          out_len_next   = leb_pkg::LEN_W'(len);
          out_last_next  = 1'b1;
          fill_next      = '0;
          state_next     = leb_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = leb_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= leb_pkg::S_IDLE;
      max_copy  <= leb_pkg::MAX_COPY_RESET;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      out_valid <= out_valid_next;
      if (cfg_we) begin
        max_copy <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    len      <= len_next;
    idx      <= idx_next;
    out_kind <= out_kind_next;
    out_data <= out_data_next;
    out_len  <= out_len_next;
    out_last <= out_last_next;
  end

  assign res.valid       = out_valid;
  assign res.kind        = out_kind;
  assign res.data        = out_data;
  assign res.line_length = out_len;
  assign res.last        = out_last;

endmodule

/* sv/leb_checker.sv */
// Port-level checks for the line edit buffer, bound to the top level.
module leb_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       key_ready,
  input logic                       res_valid,
  input logic                       res_ready,
  input logic [leb_pkg::KIND_W-1:0] res_kind,
  input logic [leb_pkg::CHAR_W-1:0] res_data,
  input logic [leb_pkg::LEN_W-1:0]  res_line_length,
  input logic                       res_last
);

  // no new key while a multi-result sequence is still in flight
  a_no_key_mid_line: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_last) |-> !key_ready)
    else $error("key ready during unfinished line delivery");

  // line done closes the sequence with zero data
  a_done_shape: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_kind == leb_pkg::KIND_DONE) |-> (res_last && res_data == '0))
    else $error("malformed line done transfer");

  // only the newline echo and line characters leave the sequence open
  a_open_kinds: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_last) |->
      (res_kind == leb_pkg::KIND_CHAR ||
       (res_kind == leb_pkg::KIND_ECHO && res_data == leb_pkg::KEY_NEWLINE)))
    else $error("unexpected non-final transfer");

  a_len_only_on_done: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_kind != leb_pkg::KIND_DONE) |-> res_line_length == '0)
    else $error("line length set outside line done");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_data) && $stable(res_kind)))
    else $error("stalled result changed");

endmodule

bind line_edit_buffer leb_checker u_leb_checker (
  .clk            (clk),
  .rst            (rst),
  .key_ready      (key.ready),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .res_kind       (res.kind),
  .res_data       (res.data),
  .res_line_length(res.line_length),
  .res_last       (res.last)
);
